### rtl/tsu_pkg.sv
// Package with the types, codes and constants shared by the subevent word unpacker.
`default_nettype none
package tsu_pkg;

    // Block ids with special meaning in a header word.
    localparam logic [15:0] ID_HDR_ONLY_LO = 16'h7000;
    localparam logic [15:0] ID_HDR_ONLY_HI = 16'h7003;
    localparam logic [15:0] ID_SKIP_A      = 16'h7005;
    localparam logic [15:0] ID_SKIP_B      = 16'h0112;
    localparam logic [15:0] ID_TERMINATOR  = 16'h5555;

    // Payload word markers in bits 30:29 when bit 31 is clear.
    localparam logic [1:0] MARK_TDC_HEADER = 2'd1;
    localparam logic [1:0] MARK_DEBUG      = 2'd2;
    localparam logic [1:0] MARK_EPOCH      = 2'd3;

    localparam int TSU_QUEUE_DEPTH = 4;
    localparam int HIT_BITS_W      = 29;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ENDED   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MODE_PROCESS  = 2'd0,
        MODE_SKIP     = 2'd1,
        MODE_SKIP_END = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        WC_HEADER     = 4'd0,
        WC_HDR_ONLY   = 4'd1,
        WC_SKIPPED    = 4'd2,
        WC_HIT        = 4'd3,
        WC_EPOCH      = 4'd4,
        WC_TDC_HEADER = 4'd5,
        WC_DEBUG      = 4'd6,
        WC_OTHER      = 4'd7,
        WC_IGNORED    = 4'd8
    } t_word_class;

    typedef struct packed {
        logic [31:0] data_word;
        logic        first_word;
    } t_tsu_in;

    typedef struct packed {
        t_word_class word_class;
        logic        hit_valid;
        logic [15:0] tdc_id;
        logic [6:0]  channel;
        logic [27:0] hit_epoch;
        logic [10:0] coarse_time;
        logic [9:0]  fine_time;
        logic        edge_res;
        logic        subevent_end;
    } t_tsu_out;

    // Classified word as it travels from the front to the back.
    typedef struct packed {
        t_word_class             cls;
        logic [15:0]             tdc_id;
        logic [HIT_BITS_W-1:0]   bits;
        logic                    epoch_clr;
        logic                    sub_end;
    } t_tsu_op;

endpackage
`default_nettype wire

### rtl/tdc_subevent_word_unpacker.sv
// Top level of the TDC subevent word unpacker: front, queue, back and checks.
`default_nettype none
// The unpacker takes one 32-bit subevent word per item and gives exactly one
// result item for each, in order. A word flagged as first_word always starts a
// new subevent and is read as a block header (length in bits 31:16, id in bits
// 15:0). The front end follows the block structure (header, payload countdown,
// end after the terminating block) and classifies every word in the cycle it is
// accepted; the back end keeps the epoch counter of the current TDC block and
// fills the hit fields. A queue of QUEUE_DEPTH items sits between the two, so
// input and output stall independently. While neither side stalls, the block
// sustains one item per clock cycle in both directions. An accepted item is
// written into the queue and moves on into the output register when that
// register is free, which presents it as a result. The input stalls only when
// the queue is full, which happens only after the output side has held results
// back. Fields that do not apply to a word class are returned as zero; words
// after the end of a subevent come out as class ignored with id zero.
module tdc_subevent_word_unpacker
    import tsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = TSU_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_tsu_in  i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_tsu_out      o_data
);

    logic    front_push;
    t_tsu_op front_op;
    logic    q_full;
    logic    q_valid;
    t_tsu_op q_op;
    logic    back_pop;

    // The front end classifies each accepted word and pushes it straight in.
    tsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (front_push),
        .o_op    (front_op),
        .i_full  (q_full)
    );

    tsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (back_pop)
    );

    // The back end drains the queue whenever its output register is free.
    tsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_op),
        .o_pop      (back_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    // A hit flag appears exactly on hit items.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hit_valid == (o_data.word_class == WC_HIT)))
        else $error("hit_valid disagrees with word class");

    // The end of a subevent is only marked on a header or a skipped payload word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.subevent_end) |->
            (o_data.word_class == WC_HEADER || o_data.word_class == WC_SKIPPED))
        else $error("subevent end on an unexpected word class");

    // Ignored words carry no block id.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.word_class == WC_IGNORED) |-> (o_data.tdc_id == 16'd0))
        else $error("ignored item with a nonzero id");

    // The input side only stalls while the output side holds a result back.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && $past(i_stall)))
        else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

### rtl/tsu_front.sv
// Front end: tracks the block structure of the subevent and classifies each word.
`default_nettype none
module tsu_front
    import tsu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_tsu_in  i_data,
    output logic          o_push,
    output t_tsu_op       o_op,
    input  wire logic     i_full
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_words_left, n_words_left;
    logic [15:0] r_id, n_id;
    t_mode       r_mode, n_mode;

    logic        accept;
    t_phase      phase_eff;
    logic [15:0] hdr_len, hdr_id, wl_dec;
    logic        hdr_only, last;
    t_mode       hdr_mode;
    logic [31:0] w;

    assign o_stall   = i_full;
    assign accept    = i_valid && !i_full;
    assign o_push    = accept;
    assign w         = i_data.data_word;
    assign phase_eff = i_data.first_word ? PH_HEADER : r_phase;
    assign hdr_len   = w[31:16];
    assign hdr_id    = w[15:0];
    assign hdr_only  = (hdr_id >= ID_HDR_ONLY_LO) && (hdr_id <= ID_HDR_ONLY_HI);
    assign wl_dec    = r_words_left - 16'd1;
    assign last      = (wl_dec == 16'd0);

    always_comb begin
        if (hdr_id == ID_TERMINATOR) begin
            hdr_mode = MODE_SKIP_END;
        end else if (hdr_id == ID_SKIP_A || hdr_id == ID_SKIP_B) begin
            hdr_mode = MODE_SKIP;
        end else begin
            hdr_mode = MODE_PROCESS;
        end
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_words_left = r_words_left;
        n_id         = r_id;
        n_mode       = r_mode;
        if (accept) begin
            unique case (phase_eff)
                PH_HEADER: begin
                    n_id = hdr_id;
                    if (hdr_only) begin
                        n_words_left = 16'd0;
                        n_phase      = PH_HEADER;
                    end else begin
                        n_words_left = hdr_len;
                        n_mode       = hdr_mode;
                        if (hdr_len != 16'd0) begin
                            n_phase = PH_PAYLOAD;
                        end else if (hdr_mode == MODE_SKIP_END) begin
                            n_phase = PH_ENDED;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_words_left = wl_dec;
                    if (last) begin
                        n_phase = (r_mode == MODE_SKIP_END) ? PH_ENDED : PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_ENDED;
                end
            endcase
        end
    end

    // Classified item for the queue.
    always_comb begin
        o_op           = '0;
        o_op.cls       = WC_IGNORED;
        o_op.bits      = w[HIT_BITS_W-1:0];
        unique case (phase_eff)
            PH_HEADER: begin
                o_op.tdc_id    = hdr_id;
                o_op.cls       = hdr_only ? WC_HDR_ONLY : WC_HEADER;
                o_op.epoch_clr = !hdr_only && (hdr_mode == MODE_PROCESS);
                o_op.sub_end   = !hdr_only && (hdr_len == 16'd0)
                                 && (hdr_mode == MODE_SKIP_END);
            end
            PH_PAYLOAD: begin
                o_op.tdc_id  = r_id;
                o_op.sub_end = last && (r_mode == MODE_SKIP_END);
                if (r_mode != MODE_PROCESS) begin
                    o_op.cls = WC_SKIPPED;
                end else if (w[31]) begin
                    o_op.cls = WC_HIT;
                end else begin
                    unique case (w[30:29])
                        MARK_TDC_HEADER: o_op.cls = WC_TDC_HEADER;
                        MARK_DEBUG:      o_op.cls = WC_DEBUG;
                        MARK_EPOCH:      o_op.cls = WC_EPOCH;
                        default:         o_op.cls = WC_OTHER;
                    endcase
                end
            end
            default: begin
                o_op.cls = WC_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_words_left <= 16'd0;
            r_id         <= 16'd0;
            r_mode       <= MODE_PROCESS;
        end else begin
            r_phase      <= n_phase;
            r_words_left <= n_words_left;
            r_id         <= n_id;
            r_mode       <= n_mode;
        end
    end

endmodule
`default_nettype wire

### rtl/tsu_queue.sv
// Small first-in first-out queue of classified items between front and back.
`default_nettype none
module tsu_queue
    import tsu_pkg::*;
#(
    parameter int DEPTH = TSU_QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_tsu_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output t_tsu_op      o_op,
    input  wire logic    i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tsu_op            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/tsu_back.sv
// Back end: keeps the epoch counter and builds the registered result item.
`default_nettype none
module tsu_back
    import tsu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_op_valid,
    input  wire t_tsu_op i_op,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_tsu_out     o_data
);

    logic        r_valid;
    t_tsu_out    r_out, n_out;
    logic [27:0] r_epoch, n_epoch;

    assign o_pop   = i_op_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out              = '0;
        n_out.word_class   = i_op.cls;
        n_out.tdc_id       = i_op.tdc_id;
        n_out.subevent_end = i_op.sub_end;
        if (i_op.cls == WC_HIT) begin
            n_out.hit_valid   = 1'b1;
            n_out.channel     = i_op.bits[28:22];
            n_out.fine_time   = i_op.bits[21:12];
            n_out.edge_res    = i_op.bits[11];
            n_out.coarse_time = i_op.bits[10:0];
            n_out.hit_epoch   = r_epoch;
        end
    end

    // A new processed block restarts the epoch; an epoch word loads it.
    always_comb begin
        n_epoch = r_epoch;
        if (o_pop) begin
            if (i_op.epoch_clr) begin
                n_epoch = 28'd0;
            end else if (i_op.cls == WC_EPOCH) begin
                n_epoch = i_op.bits[27:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_epoch <= 28'd0;
        end else begin
            r_epoch <= n_epoch;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the TDC subevent word unpacker.
`default_nettype none
module tb_top;
    import tsu_pkg::*;

    // Keeps a private copy of the block-structure state and of the epoch
    // counter. For each accepted word it predicts the one result item that
    // word must produce. Results are checked strictly in order.
    class unpack_scoreboard;
        t_phase      phase;
        t_mode       mode;
        logic [15:0] words_left;
        logic [15:0] block_id;
        logic [27:0] epoch;
        t_tsu_out    expected_q[$];
        int          errors;

        function new();
            phase      = PH_HEADER;
            mode       = MODE_PROCESS;
            words_left = '0;
            block_id   = '0;
            epoch      = '0;
            errors     = 0;
        endfunction

        function void note_word(t_tsu_in item);
            t_tsu_out    r;
            logic [31:0] w;
            logic [15:0] len;
            logic [15:0] id;
            r = '0;
            w = item.data_word;
            // A first word restarts parsing, even after the end of a subevent.
            if (item.first_word) begin
                phase = PH_HEADER;
            end
            if (phase == PH_HEADER) begin
                len = w[31:16];
                id = w[15:0];
                block_id = id;
                r.tdc_id = id;
                if (id >= ID_HDR_ONLY_LO && id <= ID_HDR_ONLY_HI) begin
                    // The length field of a header-only id means nothing.
                    words_left = '0;
                    r.word_class = WC_HDR_ONLY;
                end else begin
                    words_left = len;
                    r.word_class = WC_HEADER;
                    if (id == ID_TERMINATOR) begin
                        mode = MODE_SKIP_END;
                    end else if (id == ID_SKIP_A || id == ID_SKIP_B) begin
                        mode = MODE_SKIP;
                    end else begin
                        mode = MODE_PROCESS;
                        epoch = '0;
                    end
                    if (len != 0) begin
                        phase = PH_PAYLOAD;
                    end else if (mode == MODE_SKIP_END) begin
                        // An empty terminating block ends on its own header.
                        phase = PH_ENDED;
                        r.subevent_end = 1'b1;
                    end
                end
            end else if (phase == PH_PAYLOAD) begin
                words_left = words_left - 16'd1;
                r.tdc_id = block_id;
                if (words_left == 0) begin
                    phase = (mode == MODE_SKIP_END) ? PH_ENDED : PH_HEADER;
                end
                if (mode != MODE_PROCESS) begin
                    r.word_class = WC_SKIPPED;
                    r.subevent_end = (words_left == 0) && (mode == MODE_SKIP_END);
                end else if (w[31]) begin
                    r.word_class = WC_HIT;
                    r.hit_valid = 1'b1;
                    r.channel = w[28:22];
                    r.hit_epoch = epoch;
                    r.fine_time = w[21:12];
                    r.edge_res = w[11];
                    r.coarse_time = w[10:0];
                end else begin
                    case (w[30:29])
                        MARK_TDC_HEADER: r.word_class = WC_TDC_HEADER;
                        MARK_DEBUG: r.word_class = WC_DEBUG;
                        MARK_EPOCH: begin
                            epoch = w[27:0];
                            r.word_class = WC_EPOCH;
                        end
                        default: r.word_class = WC_OTHER;
                    endcase
                end
            end else begin
                r.word_class = WC_IGNORED;
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_tsu_out got);
            t_tsu_out want;
            if (expected_q.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            compare_field("word_class", want.word_class, got.word_class);
            compare_field("hit_valid", want.hit_valid, got.hit_valid);
            compare_field("tdc_id", want.tdc_id, got.tdc_id);
            compare_field("channel", want.channel, got.channel);
            compare_field("hit_epoch", want.hit_epoch, got.hit_epoch);
            compare_field("coarse_time", want.coarse_time, got.coarse_time);
            compare_field("fine_time", want.fine_time, got.fine_time);
            compare_field("edge_res", want.edge_res, got.edge_res);
            compare_field("subevent_end", want.subevent_end, got.subevent_end);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_tsu_in  in_data = '0;
    logic     in_stall;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_tsu_out out_data;

    // When set, neither side idles any more; the tail of the run goes at full rate.
    bit       no_idle = 1'b0;
    int       stall_left = 0;
    int       useful_words = 0;
    t_tsu_in  stim_q[$];

    unpack_scoreboard sb;

    tdc_subevent_word_unpacker dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Words the block would only ignore are marked as filler so that they do
    // not count toward the size of the random part.
    function automatic void push_word(logic [31:0] w, logic first, bit filler = 1'b0);
        t_tsu_in item;
        item.data_word = w;
        item.first_word = first;
        stim_q.push_back(item);
        if (!filler) begin
            useful_words++;
        end
    endfunction

    // A payload word of a TDC block: half of them hits, the rest spread over the
    // marker classes and unmarked words, with random content everywhere else.
    function automatic logic [31:0] tdc_payload_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w[31] = 1'b1;
            5, 6: w[31:29] = {1'b0, MARK_EPOCH};
            7: w[31:29] = {1'b0, MARK_TDC_HEADER};
            8: w[31:29] = {1'b0, MARK_DEBUG};
            default: w[31:29] = 3'b000;
        endcase
        return w;
    endfunction

    // One subevent: a few blocks of random kinds, usually closed by the
    // terminating block and a few words that must be ignored. Now and then the
    // opening first word is left out, a long block is cut short by the next
    // subevent, or a stray random word is thrown in.
    function automatic void push_subevent();
        int          blocks;
        int          kind;
        logic [15:0] len;
        logic [15:0] id;
        logic        first;
        blocks = $urandom_range(1, 4);
        for (int b = 0; b < blocks; b++) begin
            first = (b == 0) ? ($urandom_range(0, 14) != 0) : ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                id = ID_HDR_ONLY_LO + 16'($urandom_range(0, 3));
                push_word({16'($urandom), id}, first);
            end else if (kind == 8) begin
                id = ($urandom_range(0, 1) != 0) ? ID_SKIP_A : ID_SKIP_B;
                len = 16'($urandom_range(0, 4));
                push_word({len, id}, first);
                repeat (len) push_word($urandom, 1'b0);
            end else begin
                id = 16'($urandom);
                if ($urandom_range(0, 19) == 0) begin
                    push_word({16'($urandom), id}, first);
                    repeat ($urandom_range(1, 6)) push_word(tdc_payload_word(), 1'b0);
                    return;
                end
                len = 16'($urandom_range(0, 10));
                push_word({len, id}, first);
                repeat (len) push_word(tdc_payload_word(), 1'b0);
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            len = 16'($urandom_range(0, 3));
            push_word({len, ID_TERMINATOR}, 1'b0);
            repeat (len) push_word($urandom, 1'b0);
            repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0, 1'b1);
        end
        if ($urandom_range(0, 9) == 0) begin
            push_word($urandom, 1'($urandom_range(0, 1)));
        end
    endfunction

    // Directed opening, then random subevents until about 500 words that the
    // block really parses have been queued.
    function automatic void build_stimulus();
        // Header-only ids at both ends of their range, with junk lengths.
        push_word({16'h0005, ID_HDR_ONLY_LO}, 1'b1);
        push_word({16'hffff, ID_HDR_ONLY_HI}, 1'b0);
        // TDC block just below the header-only range, every payload class.
        push_word({16'h0008, 16'h6fff}, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h7fff_ffff, 1'b0);
        push_word(32'hc0a5_5a5a, 1'b0);
        push_word(32'h2000_0000, 1'b0);
        push_word(32'h4000_0000, 1'b0);
        push_word(32'h1fff_ffff, 1'b0);
        push_word(32'h6000_0000, 1'b0);
        // Empty TDC block just above the header-only range.
        push_word({16'h0000, 16'h7004}, 1'b0);
        // Both skipped ids.
        push_word({16'h0002, ID_SKIP_A}, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word({16'h0001, ID_SKIP_B}, 1'b0);
        push_word(32'h8123_4567, 1'b0);
        // Longest possible block, abandoned by a new first word.
        push_word({16'hffff, 16'h0000}, 1'b0);
        push_word(32'h8000_0800, 1'b0);
        // Terminating block with payload, then a word after the end.
        push_word({16'h0002, ID_TERMINATOR}, 1'b1);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'habcd_ef01, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        // Empty terminating block ends on its header.
        push_word({16'h0000, ID_TERMINATOR}, 1'b1);
        push_word(32'hffff_ffff, 1'b0);
        useful_words = 0;
        while (useful_words < 500) begin
            push_subevent();
        end
    endfunction

    // Offers one item from the falling edge on, sometimes after an idle
    // burst, and holds it until the block takes it.
    task automatic send_word(t_tsu_in item, bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Output-side stall in bursts of random length.
    always @(negedge clk) begin
        if (!no_idle && stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Both handshakes are observed at the rising edge with pre-edge values.
    // The input is noted first, although with the block's latency a result can
    // never belong to a word taken in the same cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_word(in_data);
            end
            if (out_valid && !out_stall) begin
                sb.check_result(out_data);
            end
        end
    end

    initial begin
        int waited;
        sb = new();
        build_stimulus();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        foreach (stim_q[i]) begin
            if (i == stim_q.size() - 60) begin
                no_idle = 1'b1;
            end
            send_word(stim_q[i], !no_idle);
        end
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        // A few more cycles so that a stray extra result would still be seen.
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result items never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
